@@ src/jmsp_pkg.sv @@
package jmsp_pkg;

  // Marker and byte codes
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] MRK_TEM  = 8'h01;
  localparam logic [7:0] MRK_RST0 = 8'hD0;
  localparam logic [7:0] MRK_RST7 = 8'hD7;
  localparam logic [7:0] MRK_SOI  = 8'hD8;
  localparam logic [7:0] MRK_EOI  = 8'hD9;
  localparam logic [7:0] MRK_SOS  = 8'hDA;
  localparam logic [7:0] MRK_SOF0 = 8'hC0;
  localparam logic [7:0] MRK_SOFF = 8'hCF;
  localparam logic [7:0] MRK_DHT  = 8'hC4;
  localparam logic [7:0] MRK_JPG  = 8'hC8;
  localparam logic [7:0] MRK_DAC  = 8'hCC;

  // Shortest segment length whose frame header carries height and width
  localparam logic [15:0] SOF_MIN_LEN = 16'd7;
  localparam logic [15:0] LEN_MIN     = 16'd2;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_NO_PREFIX = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // One result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] end_offset;
    logic        dims_found;
    logic [15:0] image_height;
    logic [15:0] image_width;
  } result_t;

  // Frame header markers: C0-CF except DHT, JPG and DAC
  function automatic logic is_sof(input logic [7:0] m);
    logic in_range;
    in_range = (m inside {[MRK_SOF0:MRK_SOFF]});
    return in_range && (m != MRK_DHT) && (m != MRK_JPG) && (m != MRK_DAC);
  endfunction

endpackage

@@ src/jmsp_in_reg.sv @@
module jmsp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       last_byte_i,
  input  logic       free_i,
  output logic       step_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  // Advance the held byte whenever the result side has room
  assign step_o     = valid_q && free_i;
  assign in_ready_o = !valid_q || step_o;
  assign take       = in_valid_i && in_ready_o;
  assign byte_o     = byte_q;
  assign last_o     = last_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_value_i;
      last_q <= last_byte_i;
    end
  end

endmodule

@@ src/jmsp_parse_core.sv @@
module jmsp_parse_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              byte_i,
  input  logic                    last_i,
  input  logic [31:0]             start_offset_i,
  output logic                    res_valid_o,
  output jmsp_pkg::result_t       res_o
);

  localparam logic [3:0] PH_START0  = 4'd0;
  localparam logic [3:0] PH_START1  = 4'd1;
  localparam logic [3:0] PH_PREFIX  = 4'd2;
  localparam logic [3:0] PH_MARKER  = 4'd3;
  localparam logic [3:0] PH_LEN_HI  = 4'd4;
  localparam logic [3:0] PH_LEN_LO  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_ENTROPY = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [7:0]  marker_q, marker_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] left_q, left_d;
  logic [2:0]  idx_q, idx_d;
  logic        cap_q, cap_d;
  logic        prev_ff_q, prev_ff_d;
  logic [15:0] height_q, height_d;
  logic [15:0] width_q, width_d;
  logic        dims_q, dims_d;

  logic [31:0] here;
  logic [15:0] seg_len;
  logic [15:0] left_dec;
  logic        emit;
  logic [2:0]  emit_status;
  logic [31:0] emit_end;
  logic [3:0]  after_seg;
  logic        after_ff;

  assign here     = count_q + 32'd1;
  assign seg_len  = {len_hi_q, byte_i};
  assign left_dec = left_q - 16'd1;

  // Next phase once a segment ends: entropy data follows the scan header
  always_comb begin
    if (marker_q == jmsp_pkg::MRK_SOS) begin
      after_seg = PH_ENTROPY;
      after_ff  = 1'b0;
    end else begin
      after_seg = PH_PREFIX;
      after_ff  = prev_ff_q;
    end
  end

  // Walk one byte through the segment state
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    marker_d    = marker_q;
    len_hi_d    = len_hi_q;
    left_d      = left_q;
    idx_d       = idx_q;
    cap_d       = cap_q;
    prev_ff_d   = prev_ff_q;
    height_d    = height_q;
    width_d     = width_q;
    dims_d      = dims_q;
    emit        = 1'b0;
    emit_status = jmsp_pkg::ST_OK;
    emit_end    = '0;
    if (step_i) begin
      count_d = here;
      case (phase_q)
        PH_START0: begin
          if (byte_i != jmsp_pkg::BYTE_FF) begin
            emit = 1'b1; emit_status = jmsp_pkg::ST_BAD_START; phase_d = PH_DONE;
          end else begin
            phase_d = PH_START1;
          end
        end
        PH_START1: begin
          if (byte_i != jmsp_pkg::MRK_SOI) begin
            emit = 1'b1; emit_status = jmsp_pkg::ST_BAD_START; phase_d = PH_DONE;
          end else begin
            phase_d = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          if (byte_i != jmsp_pkg::BYTE_FF) begin
            emit = 1'b1; emit_status = jmsp_pkg::ST_NO_PREFIX; phase_d = PH_DONE;
          end else begin
            phase_d = PH_MARKER;
          end
        end
        PH_MARKER: begin
          if (byte_i == jmsp_pkg::BYTE_FF) begin
            phase_d = PH_MARKER;
          end else if (byte_i == jmsp_pkg::MRK_TEM || byte_i == jmsp_pkg::MRK_SOI ||
                       (byte_i inside {[jmsp_pkg::MRK_RST0:jmsp_pkg::MRK_RST7]})) begin
            phase_d = PH_PREFIX;
          end else if (byte_i == jmsp_pkg::MRK_EOI) begin
            emit = 1'b1; emit_end = start_offset_i + here; phase_d = PH_DONE;
          end else begin
            marker_d = byte_i;
            phase_d  = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi_d = byte_i;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < jmsp_pkg::LEN_MIN) begin
            emit = 1'b1; emit_status = jmsp_pkg::ST_BAD_LEN; phase_d = PH_DONE;
          end else begin
            left_d = seg_len - jmsp_pkg::LEN_MIN;
            idx_d  = '0;
            cap_d  = !dims_q && jmsp_pkg::is_sof(marker_q) &&
                     (seg_len >= jmsp_pkg::SOF_MIN_LEN);
            if (seg_len == jmsp_pkg::LEN_MIN) begin
              phase_d   = after_seg;
              prev_ff_d = after_ff;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          // Capture height and width from payload bytes one to four
          if (cap_q) begin
            case (idx_q)
              3'd1:    height_d = {byte_i, height_q[7:0]};
              3'd2:    height_d = {height_q[15:8], byte_i};
              3'd3:    width_d  = {byte_i, width_q[7:0]};
              3'd4:    width_d  = {width_q[15:8], byte_i};
              default: ;
            endcase
          end
          if (idx_q != 3'd7) begin
            idx_d = idx_q + 3'd1;
          end
          left_d = left_dec;
          if (left_dec == '0) begin
            if (cap_q) begin
              dims_d = 1'b1;
            end
            phase_d   = after_seg;
            prev_ff_d = after_ff;
          end
        end
        PH_ENTROPY: begin
          if (prev_ff_q && byte_i == jmsp_pkg::MRK_EOI) begin
            emit = 1'b1; emit_end = start_offset_i + here; phase_d = PH_DONE;
          end
          prev_ff_d = (byte_i == jmsp_pkg::BYTE_FF);
        end
        default: phase_d = PH_DONE;
      endcase
      // Report truncation on the last byte when nothing else was reported
      if (last_i && !emit && phase_d != PH_DONE) begin
        emit        = 1'b1;
        emit_status = jmsp_pkg::ST_TRUNC;
        emit_end    = '0;
      end
    end
  end

  // Build the result from the state after this byte
  always_comb begin
    res_valid_o           = emit;
    res_o.status          = emit_status;
    res_o.end_offset      = emit_end;
    res_o.dims_found      = dims_d;
    res_o.image_height    = dims_d ? height_d : '0;
    res_o.image_width     = dims_d ? width_d : '0;
  end

  // Update state; restart after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START0;
      count_q   <= '0;
      marker_q  <= '0;
      len_hi_q  <= '0;
      left_q    <= '0;
      idx_q     <= '0;
      cap_q     <= 1'b0;
      prev_ff_q <= 1'b0;
      height_q  <= '0;
      width_q   <= '0;
      dims_q    <= 1'b0;
    end else if (step_i && last_i) begin
      phase_q   <= PH_START0;
      count_q   <= '0;
      marker_q  <= '0;
      len_hi_q  <= '0;
      left_q    <= '0;
      idx_q     <= '0;
      cap_q     <= 1'b0;
      prev_ff_q <= 1'b0;
      height_q  <= '0;
      width_q   <= '0;
      dims_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      marker_q  <= marker_d;
      len_hi_q  <= len_hi_d;
      left_q    <= left_d;
      idx_q     <= idx_d;
      cap_q     <= cap_d;
      prev_ff_q <= prev_ff_d;
      height_q  <= height_d;
      width_q   <= width_d;
      dims_q    <= dims_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> step_i)
    else $error("result raised without a byte step");
  a_error_zero_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != jmsp_pkg::ST_OK) |-> (res_o.end_offset == '0))
    else $error("error result carries a nonzero end offset");
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (phase_q == PH_START0 && count_q == '0 && !dims_q))
    else $error("parser did not restart after the last byte");
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_DONE) |-> !res_valid_o)
    else $error("result raised after the buffer was already finished");
  a_dims_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dims_q && !(($past(step_i)) && $past(last_i))) |-> $stable(height_q))
    else $error("captured height changed after capture");
`endif

endmodule

@@ src/jmsp_out_reg.sv @@
module jmsp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  jmsp_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jmsp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  jmsp_pkg::result_t res_q;

  // Room for a new result when empty or the current one leaves now
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ src/jpeg_marker_stream_parser_top.sv @@
// JPEG marker stream parser.
// Input channel (in_valid_i / in_ready_o): one buffer byte per request, with
// last_byte_i set on the final byte of the buffer. Output channel
// (out_valid_o / out_ready_i): at most one result per buffer, carrying the
// status, the end offset after EOI (start offset added) and the frame size
// taken from the first qualifying frame header.
// cfg_wr_en_i / cfg_wr_data_i write the start offset; write it between buffers
// or while no result is pending.
// The byte deciding the result sits in the input register, then the parse
// logic writes the result register, which drives out_valid_o.
// Throughput: one byte per cycle unless the result register is full; each
// byte passes the parse logic between the input and result registers.
// When the receiver stalls, the pending result holds; the input register
// still takes one more byte, and then in_ready_o drops until the result
// register frees up.
// Reset clears both registers' valid flags, the parse state and the start
// offset; the parser also restarts by itself after every last byte.
module jpeg_marker_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] end_offset_o,
  output logic        dims_found_o,
  output logic [15:0] image_height_o,
  output logic [15:0] image_width_o
);

  logic              free;
  logic              step;
  logic [7:0]        cur_byte;
  logic              cur_last;
  logic              res_valid;
  jmsp_pkg::result_t res;
  jmsp_pkg::result_t out_res;
  logic [31:0]       start_offset_q;

  // Start offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q <= '0;
    end else if (cfg_wr_en_i) begin
      start_offset_q <= cfg_wr_data_i;
    end
  end

  jmsp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .free_i       (free),
    .step_o       (step),
    .byte_o       (cur_byte),
    .last_o       (cur_last)
  );

  jmsp_parse_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .byte_i         (cur_byte),
    .last_i         (cur_last),
    .start_offset_i (start_offset_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  jmsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign status_o       = out_res.status;
  assign end_offset_o   = out_res.end_offset;
  assign dims_found_o   = out_res.dims_found;
  assign image_height_o = out_res.image_height;
  assign image_width_o  = out_res.image_width;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  // Parser walk, one state per expected kind of byte
  typedef enum logic [3:0] {
    PH_SOI0, PH_SOI1, PH_PREFIX, PH_MARKER, PH_LEN_HI, PH_LEN_LO,
    PH_PAYLOAD, PH_ENTROPY, PH_DONE
  } parse_phase_e;

  // One row of the directed table; fixed rows carry a typed-in result
  typedef struct packed {
    logic [7:0]        value;
    logic              last;
    logic              fixed;
    jmsp_pkg::result_t want;
  } stim_row_t;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES = 180;
  localparam int unsigned N_PHASES    = 6;
  localparam int unsigned N_ROWS      = 26;

  localparam jmsp_pkg::result_t R_NONE      = '0;
  localparam jmsp_pkg::result_t R_BAD_START =
    '{jmsp_pkg::ST_BAD_START, 32'd0, 1'b0, 16'd0, 16'd0};
  localparam jmsp_pkg::result_t R_TRUNC     =
    '{jmsp_pkg::ST_TRUNC, 32'd0, 1'b0, 16'd0, 16'd0};
  localparam jmsp_pkg::result_t R_PREFIX_HW =
    '{jmsp_pkg::ST_NO_PREFIX, 32'd0, 1'b1, 16'hFFFF, 16'hFFFF};

  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    // bad start, then a byte that is ignored up to the last flag
    '{8'h00, 1'b0, 1'b1, R_BAD_START},
    '{8'hFF, 1'b1, 1'b0, R_NONE},
    // one-byte buffer ends truncated
    '{8'hFF, 1'b1, 1'b1, R_TRUNC},
    // fill byte, TEM, frame header with all-ones size, then a missing
    // prefix on the last byte: the value error wins and keeps the size
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hD8, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'h01, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hC1, 1'b0, 1'b0, R_NONE},
    '{8'h00, 1'b0, 1'b0, R_NONE},
    '{8'h07, 1'b0, 1'b0, R_NONE},
    '{8'h08, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'h55, 1'b1, 1'b1, R_PREFIX_HW},
    // empty scan header, then EOI on the last byte
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hD8, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hDA, 1'b0, 1'b0, R_NONE},
    '{8'h00, 1'b0, 1'b0, R_NONE},
    '{8'h02, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'hD9, 1'b1, 1'b0, R_NONE}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i;
  logic [31:0] cfg_wr_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  byte_value_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [31:0] end_offset_o;
  logic        dims_found_o;
  logic [15:0] image_height_o;
  logic [15:0] image_width_o;

  // Predicted parser state and register copy
  logic [31:0]  start_ofs;
  parse_phase_e phase;
  logic [31:0]  byte_cnt;
  logic [7:0]   seg_marker;
  logic [15:0]  seg_len;
  logic [15:0]  payload_left;
  logic         prev_ff;
  logic [15:0]  height_q;
  logic [15:0]  width_q;
  logic         dims_seen;

  jmsp_pkg::result_t results_due [$];
  logic [7:0]        jpeg_bytes [$];
  int unsigned       mismatch_count = 0;
  int unsigned       results_taken = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       stall_cycles = 0;
  bit                calm = 1'b0;

  jpeg_marker_stream_parser_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .end_offset_o   (end_offset_o),
    .dims_found_o   (dims_found_o),
    .image_height_o (image_height_o),
    .image_width_o  (image_width_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Add one byte to the end of the buffer under construction
  task automatic append_byte(input logic [7:0] b);
    jpeg_bytes = {jpeg_bytes, b};
  endtask

  // Add one expected result behind the pending ones
  task automatic expect_result(input jmsp_pkg::result_t r);
    results_due = {results_due, r};
  endtask

  function automatic logic frame_marker(input logic [7:0] m);
    return (m[7:4] == 4'hC) && (m != jmsp_pkg::MRK_DHT) &&
           (m != jmsp_pkg::MRK_JPG) && (m != jmsp_pkg::MRK_DAC);
  endfunction

  task automatic restart_parse();
    phase        = PH_SOI0;
    byte_cnt     = '0;
    seg_marker   = '0;
    seg_len      = '0;
    payload_left = '0;
    prev_ff      = 1'b0;
    height_q     = '0;
    width_q      = '0;
    dims_seen    = 1'b0;
  endtask

  function automatic jmsp_pkg::result_t parse_outcome(input logic [2:0] st,
                                                      input logic [31:0] eo);
    jmsp_pkg::result_t r;
    r.status       = st;
    r.end_offset   = eo;
    r.dims_found   = dims_seen;
    r.image_height = dims_seen ? height_q : 16'd0;
    r.image_width  = dims_seen ? width_q : 16'd0;
    return r;
  endfunction

  // Advance the predicted parser by one byte; got is set when it yields a result
  task automatic parse_jpeg_byte(input logic [7:0] b, input logic last,
                                 output bit got, output jmsp_pkg::result_t res);
    logic [31:0] here;
    logic [15:0] idx;
    logic        hdr;
    got  = 1'b0;
    res  = '0;
    here = byte_cnt + 32'd1;
    case (phase)
      PH_SOI0: begin
        if (b != jmsp_pkg::BYTE_FF) begin
          got = 1'b1; res = parse_outcome(jmsp_pkg::ST_BAD_START, '0); phase = PH_DONE;
        end else phase = PH_SOI1;
      end
      PH_SOI1: begin
        if (b != jmsp_pkg::MRK_SOI) begin
          got = 1'b1; res = parse_outcome(jmsp_pkg::ST_BAD_START, '0); phase = PH_DONE;
        end else phase = PH_PREFIX;
      end
      PH_PREFIX: begin
        if (b != jmsp_pkg::BYTE_FF) begin
          got = 1'b1; res = parse_outcome(jmsp_pkg::ST_NO_PREFIX, '0); phase = PH_DONE;
        end else phase = PH_MARKER;
      end
      PH_MARKER: begin
        // fill bytes keep us here; standalone markers carry no length
        if (b == jmsp_pkg::BYTE_FF) begin
          phase = PH_MARKER;
        end else if (b == jmsp_pkg::MRK_TEM || b == jmsp_pkg::MRK_SOI ||
                     (b >= jmsp_pkg::MRK_RST0 && b <= jmsp_pkg::MRK_RST7)) begin
          phase = PH_PREFIX;
        end else if (b == jmsp_pkg::MRK_EOI) begin
          got = 1'b1; res = parse_outcome(jmsp_pkg::ST_OK, start_ofs + here);
          phase = PH_DONE;
        end else begin
          seg_marker = b;
          phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        seg_len = {b, 8'h00};
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seg_len = {seg_len[15:8], b};
        if (seg_len < jmsp_pkg::LEN_MIN) begin
          got = 1'b1; res = parse_outcome(jmsp_pkg::ST_BAD_LEN, '0); phase = PH_DONE;
        end else begin
          payload_left = seg_len - jmsp_pkg::LEN_MIN;
          if (payload_left != 0) phase = PH_PAYLOAD;
          else if (seg_marker == jmsp_pkg::MRK_SOS) begin
            phase = PH_ENTROPY; prev_ff = 1'b0;
          end else phase = PH_PREFIX;
        end
      end
      PH_PAYLOAD: begin
        idx = seg_len - jmsp_pkg::LEN_MIN - payload_left;
        hdr = !dims_seen && frame_marker(seg_marker) && (seg_len >= jmsp_pkg::SOF_MIN_LEN);
        // capture height and width from the frame header payload
        if (hdr) begin
          case (idx)
            16'd1: height_q[15:8] = b;
            16'd2: height_q[7:0]  = b;
            16'd3: width_q[15:8]  = b;
            16'd4: width_q[7:0]   = b;
            default: ;
          endcase
        end
        payload_left = payload_left - 16'd1;
        if (payload_left == 0) begin
          if (hdr) dims_seen = 1'b1;
          if (seg_marker == jmsp_pkg::MRK_SOS) begin
            phase = PH_ENTROPY; prev_ff = 1'b0;
          end else phase = PH_PREFIX;
        end
      end
      PH_ENTROPY: begin
        if (prev_ff && b == jmsp_pkg::MRK_EOI) begin
          got = 1'b1; res = parse_outcome(jmsp_pkg::ST_OK, start_ofs + here);
          phase = PH_DONE;
        end
        prev_ff = (b == jmsp_pkg::BYTE_FF);
      end
      default: phase = PH_DONE;
    endcase
    byte_cnt = here;
    if (last) begin
      if (!got && phase != PH_DONE) begin
        got = 1'b1;
        res = parse_outcome(jmsp_pkg::ST_TRUNC, '0);
      end
      restart_parse();
    end
  endtask

  // Offer one byte, hold it until taken, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic fixed, input jmsp_pkg::result_t want);
    bit                got;
    jmsp_pkg::result_t res;
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    last_byte_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    parse_jpeg_byte(b, last, got, res);
    if (fixed) expect_result(want);
    else if (got) expect_result(res);
    bytes_sent++;
  endtask

  // Let the block run empty before touching the register or ending
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_start_offset(input logic [31:0] v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    start_ofs = v;
  endtask

  // Build one buffer: mostly well-formed files with random content,
  // the rest noise, corrupted or cut short
  task automatic make_jpeg();
    int unsigned kind;
    int unsigned nseg;
    int unsigned s;
    int unsigned n;
    int unsigned cut;
    logic [7:0]  m;
    logic [15:0] len;
    bit          open_seg;
    jpeg_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(6, 1);
      repeat (n) append_byte(8'($urandom_range(255)));
      if ($urandom_range(1) == 1) jpeg_bytes[0] = jmsp_pkg::BYTE_FF;
      return;
    end
    append_byte(jmsp_pkg::BYTE_FF);
    append_byte(jmsp_pkg::MRK_SOI);
    open_seg = 1'b0;
    nseg = $urandom_range(4);
    for (s = 0; s < nseg && !open_seg; s++) begin
      case ($urandom_range(9))
        0, 1: begin
          // standalone marker, fill bytes in front now and then
          append_byte(jmsp_pkg::BYTE_FF);
          repeat ($urandom_range(2)) append_byte(jmsp_pkg::BYTE_FF);
          case ($urandom_range(9))
            0: append_byte(jmsp_pkg::MRK_TEM);
            1: append_byte(jmsp_pkg::MRK_SOI);
            default: append_byte(jmsp_pkg::MRK_RST0 + 8'($urandom_range(7)));
          endcase
        end
        2, 3: begin
          // frame header, sometimes too short to carry the size
          do m = jmsp_pkg::MRK_SOF0 + 8'($urandom_range(15));
          while (m == jmsp_pkg::MRK_DHT || m == jmsp_pkg::MRK_JPG || m == jmsp_pkg::MRK_DAC);
          len = ($urandom_range(3) == 0) ? 16'($urandom_range(6, 2)) :
                                           16'($urandom_range(11, 7));
          append_byte(jmsp_pkg::BYTE_FF);
          append_byte(m);
          append_byte(len[15:8]);
          append_byte(len[7:0]);
          repeat (len - 2) append_byte(8'($urandom_range(255)));
        end
        default: begin
          do m = 8'($urandom_range(255));
          while (m == jmsp_pkg::BYTE_FF || m == jmsp_pkg::MRK_TEM || m == jmsp_pkg::MRK_SOS ||
                 (m >= jmsp_pkg::MRK_RST0 && m <= jmsp_pkg::MRK_EOI));
          case ($urandom_range(29))
            0: len = 16'($urandom_range(1));
            1: begin
              len = 16'($urandom_range(65535));
              open_seg = 1'b1;
            end
            default: len = 16'($urandom_range(8, 2));
          endcase
          append_byte(jmsp_pkg::BYTE_FF);
          append_byte(m);
          append_byte(len[15:8]);
          append_byte(len[7:0]);
          if (open_seg) repeat ($urandom_range(6)) append_byte(8'($urandom_range(255)));
          else if (len >= 2) repeat (len - 2) append_byte(8'($urandom_range(255)));
        end
      endcase
    end
    if (!open_seg) begin
      append_byte(jmsp_pkg::BYTE_FF);
      if ($urandom_range(9) == 0) begin
        append_byte(jmsp_pkg::MRK_EOI);
      end else begin
        // scan header, entropy data with stuffing and restarts, then EOI
        append_byte(jmsp_pkg::MRK_SOS);
        len = 16'($urandom_range(6, 2));
        append_byte(len[15:8]);
        append_byte(len[7:0]);
        repeat (len - 2) append_byte(8'($urandom_range(255)));
        n = $urandom_range(12);
        repeat (n) begin
          m = ($urandom_range(7) == 0) ? jmsp_pkg::BYTE_FF : 8'($urandom_range(255));
          append_byte(m);
          if (m == jmsp_pkg::BYTE_FF) begin
            case ($urandom_range(3))
              0: append_byte(8'h00);
              1: append_byte(jmsp_pkg::MRK_RST0 + 8'($urandom_range(7)));
              default: ;
            endcase
          end
        end
        append_byte(jmsp_pkg::BYTE_FF);
        append_byte(jmsp_pkg::MRK_EOI);
      end
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(3, 1)) append_byte(8'($urandom_range(255)));
    end
    if (kind >= 85) begin
      if ($urandom_range(1) == 1) begin
        jpeg_bytes[$urandom_range(jpeg_bytes.size() - 1)] = 8'($urandom_range(255));
      end else begin
        cut = $urandom_range(jpeg_bytes.size(), 1);
        while (jpeg_bytes.size() > cut) void'(jpeg_bytes.pop_back());
      end
    end
  endtask

  // Drive reset, the directed table, then phases of random buffers
  initial begin : stimulus
    logic [31:0] ofs_list [N_PHASES];
    int unsigned p;
    int unsigned k;
    int unsigned target;
    in_valid_i    <= 1'b0;
    byte_value_i  <= '0;
    last_byte_i   <= 1'b0;
    cfg_wr_en_i   <= 1'b0;
    cfg_wr_data_i <= '0;
    start_ofs = '0;
    restart_parse();
    ofs_list = '{32'hFFFF_FFFF, 32'h8000_0000, $urandom, 32'd0, 32'hFFFF_FFF8, $urandom};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < N_ROWS; k++)
      send_byte(DIRECTED_ROWS[k].value, DIRECTED_ROWS[k].last,
                DIRECTED_ROWS[k].fixed, DIRECTED_ROWS[k].want);

    for (p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_start_offset(ofs_list[p]);
      calm = (p == 2);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        make_jpeg();
        for (k = 0; k < jpeg_bytes.size(); k++)
          send_byte(jpeg_bytes[k], k == jpeg_bytes.size() - 1, 1'b0, R_NONE);
      end
    end

    drain_results();
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Take results, compare with the oldest prediction, and pace out_ready_i
  initial begin : result_sink
    jmsp_pkg::result_t got;
    jmsp_pkg::result_t want;
    int unsigned       hold_left;
    bit                held_off;
    hold_left = 0;
    held_off  = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{status_o, end_offset_o, dims_found_o, image_height_o, image_width_o};
        if (results_due.size() == 0) begin
          log_mismatch($sformatf("result with nothing expected, status %0d", got.status));
        end else begin
          want = results_due.pop_front();
          if (got.status != want.status)
            log_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.end_offset != want.end_offset)
            log_mismatch($sformatf("end_offset %0h, want %0h", got.end_offset, want.end_offset));
          if (got.dims_found != want.dims_found)
            log_mismatch($sformatf("dims_found %0d, want %0d", got.dims_found, want.dims_found));
          if (got.image_height != want.image_height)
            log_mismatch($sformatf("image_height %0h, want %0h",
                                   got.image_height, want.image_height));
          if (got.image_width != want.image_width)
            log_mismatch($sformatf("image_width %0h, want %0h",
                                   got.image_width, want.image_width));
        end
        results_taken++;
      end
      // hold off once for a long stretch so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held_off && results_taken >= 30) begin
        held_off  = 1'b1;
        hold_left = 199;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
